// File: design/alu16_pkg.sv
// ============================================================================
// alu16_pkg
// Shared types and constants for the 16-bit add/sub/mul/div unit.
// ============================================================================
`default_nettype none
package alu16_pkg;
  localparam int unsigned DataW = 16;
  localparam int unsigned ProdW = 2 * DataW;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  // Item carried along the cell row
  typedef struct packed {
    logic             vld;
    op_e              op;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
    logic [DataW-1:0] rem;    // partial remainder (div)
    logic [DataW-1:0] quo;    // quotient bits (div)
    logic [ProdW-1:0] acc;    // partial product (mul) or add/sub result
    logic             ovf;
  } slot_t;
endpackage
`default_nettype wire

// File: design/alu16_cell.sv
// ============================================================================
// alu16_cell
// One step cell: one multiplier bit and one restoring divide bit per cycle while en_i is high.
// ============================================================================
`default_nettype none
module alu16_cell #(
  parameter int unsigned Step = 0
) (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire alu16_pkg::slot_t slot_i,
  output alu16_pkg::slot_t     slot_o
);
  import alu16_pkg::*;

  slot_t            slot_d, slot_q;
  logic [DataW:0]   trial;
  logic [DataW:0]   diff;

  // Combinational step on the incoming item
  always_comb begin
    slot_d = slot_i;
    trial  = {slot_i.rem, slot_i.a[DataW-1-Step]};
    diff   = trial - {1'b0, slot_i.b};
    if (slot_i.op == OP_MUL) begin
      if (slot_i.b[Step]) begin
        slot_d.acc = slot_i.acc + ({{DataW{1'b0}}, slot_i.a} << Step);
      end
    end else if (slot_i.op == OP_DIV) begin
      if (!diff[DataW]) begin
        slot_d.rem = diff[DataW-1:0];
        slot_d.quo[DataW-1-Step] = 1'b1;
      end else begin
        slot_d.rem = trial[DataW-1:0];
      end
    end
  end

  // Stage register, payload only; valid travels in the struct
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      slot_q <= slot_d;
    end
  end

  assign slot_o = slot_q;
endmodule
`default_nettype wire

// File: design/alu16_add_sub_mul_div.sv
// ============================================================================
// alu16_add_sub_mul_div
// 16-bit ALU: add, subtract, unsigned multiply and unsigned divide.
// ============================================================================
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries operation, operand_a and
//   operand_b. Output channel (out_valid_o/out_ready_i) returns result,
//   wide_product, remainder, overflow and divide_by_zero, one per input.
//   Config channel (cfg_valid_i/cfg_ready_o) writes signed_mode; write only
//   while no transaction is in flight.
//   Every operation passes a row of 16 step cells (one multiplier bit and
//   one divide bit per cell) plus an output register. Throughput is one
//   transaction per cycle unless the receiver stalls; all ops share the row.
//   When the receiver stalls the whole row holds; the input stays ready
//   while the output register is empty or being drained.
//   Reset clears the vld_q valid flags and signed_mode; data registers,
//   including the vld bit in each cell's slot, are not reset.
// ============================================================================
`default_nettype none
module alu16_add_sub_mul_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic                          cfg_signed_mode_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    operation_i,
  input  wire logic [alu16_pkg::DataW-1:0]   operand_a_i,
  input  wire logic [alu16_pkg::DataW-1:0]   operand_b_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [alu16_pkg::DataW-1:0]        result_o,
  output logic [alu16_pkg::ProdW-1:0]        wide_product_o,
  output logic [alu16_pkg::DataW-1:0]        remainder_o,
  output logic                               overflow_o,
  output logic                               divide_by_zero_o
);
  import alu16_pkg::*;

  slot_t            row [DataW+1];
  logic [DataW:0]   vld_q;
  logic             adv;
  logic             mode_q;
  slot_t            head;
  logic [DataW:0]   sum;
  logic [DataW:0]   dif;
  slot_t            tail;

  // Config register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      mode_q <= cfg_signed_mode_i;
    end
  end

  // Row advances unless the output register holds an untaken result
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // Head: add/sub resolved up front, mul/div seeded
  always_comb begin
    head      = '0;
    head.vld  = in_valid_i;
    head.op   = op_e'(operation_i);
    head.a    = operand_a_i;
    head.b    = operand_b_i;
    sum       = {1'b0, operand_a_i} + {1'b0, operand_b_i};
    dif       = {1'b0, operand_a_i} - {1'b0, operand_b_i};
    if (head.op == OP_ADD) begin
      head.acc = {{DataW{1'b0}}, sum[DataW-1:0]};
      head.ovf = mode_q ? (operand_a_i[DataW-1] == operand_b_i[DataW-1]) &&
                          (sum[DataW-1] != operand_a_i[DataW-1])
                        : sum[DataW];
    end else if (head.op == OP_SUB) begin
      head.acc = {{DataW{1'b0}}, dif[DataW-1:0]};
      head.ovf = mode_q ? (operand_a_i[DataW-1] != operand_b_i[DataW-1]) &&
                          (dif[DataW-1] != operand_a_i[DataW-1])
                        : dif[DataW];
    end
  end
  assign row[0] = head;

  // Row of step cells
  for (genvar g = 0; g < DataW; g++) begin : g_cell
    alu16_cell #(.Step(g)) u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .slot_i (row[g]),
      .slot_o (row[g+1])
    );
  end

  // Valid flags along the row and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[DataW-1:0], in_valid_i};
    end
  end
  assign out_valid_o = vld_q[DataW];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tail <= row[DataW];
    end
  end

  // Output formatting
  always_comb begin
    result_o         = '0;
    wide_product_o   = '0;
    remainder_o      = '0;
    overflow_o       = 1'b0;
    divide_by_zero_o = 1'b0;
    case (tail.op)
      OP_ADD, OP_SUB: begin
        result_o   = tail.acc[DataW-1:0];
        overflow_o = tail.ovf;
      end
      OP_MUL: begin
        result_o       = tail.acc[DataW-1:0];
        wide_product_o = tail.acc;
        overflow_o     = |tail.acc[ProdW-1:DataW];
      end
      OP_DIV: begin
        if (tail.b == '0) begin
          divide_by_zero_o = 1'b1;
        end else begin
          result_o    = tail.quo;
          remainder_o = tail.rem;
        end
      end
      default: begin
        result_o = '0;
      end
    endcase
  end
endmodule
`default_nettype wire

// File: design/alu16_checker.sv
// ============================================================================
// alu16_checker
// Port-level checks for the 16-bit ALU, bound to the top level.
// ============================================================================
`default_nettype none
module alu16_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [15:0] result_o,
  input wire logic [31:0] wide_product_o,
  input wire logic        overflow_o,
  input wire logic        divide_by_zero_o
);
  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_o))
    else $error("result changed while stalled");

  // Input ready whenever output is free
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> in_ready_o)
    else $error("input blocked with free output");

  // Divide by zero gives zero result and no overflow
  a_dz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divide_by_zero_o |-> !overflow_o && result_o == 16'd0)
    else $error("divide by zero outputs not clear");

  // Product low half mirrors result
  a_prod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && wide_product_o != 32'd0 |-> wide_product_o[15:0] == result_o)
    else $error("product and result disagree");
endmodule

bind alu16_add_sub_mul_div alu16_checker u_alu16_checker (.*);
`default_nettype wire

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// ALU16 add/sub/mul/div testbench
// Drives operations through the valid/ready input channel and compares each
// returned transaction against a predicted result in arrival order. Covers
// operand extremes, both overflow modes, divide by zero, backpressure and
// random traffic.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import alu16_pkg::*;

  localparam int unsigned Latency   = 18;
  localparam int unsigned WdogLimit = 20000;

  typedef struct packed {
    logic [DataW-1:0] res;
    logic [ProdW-1:0] prod;
    logic [DataW-1:0] rem;
    logic             ovf;
    logic             dz;
  } alu_res_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic             cfg_signed_mode_i;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [1:0]       operation_i;
  logic [DataW-1:0] operand_a_i;
  logic [DataW-1:0] operand_b_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [DataW-1:0] result_o;
  logic [ProdW-1:0] wide_product_o;
  logic [DataW-1:0] remainder_o;
  logic             overflow_o;
  logic             divide_by_zero_o;

  alu16_add_sub_mul_div dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_signed_mode_i,
    .in_valid_i, .in_ready_o, .operation_i, .operand_a_i, .operand_b_i,
    .out_valid_o, .out_ready_i, .result_o, .wide_product_o, .remainder_o,
    .overflow_o, .divide_by_zero_o
  );

  alu_res_t    expected_q[$];
  logic        mode_signed;
  int unsigned error_count;
  bit          send_gaps;
  bit          recv_gaps;
  int unsigned hold_cycles;
  int unsigned idle_cycles;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Compute the expected transaction for one operation
  function automatic alu_res_t alu_predict(op_e op, logic [DataW-1:0] a,
                                           logic [DataW-1:0] b, logic sgn);
    alu_res_t         r;
    logic [DataW:0]   wide;
    logic [ProdW-1:0] p;
    r = '0;
    case (op)
      OP_ADD: begin
        wide = {1'b0, a} + {1'b0, b};
        r.res = wide[DataW-1:0];
        r.ovf = sgn ? (a[15] == b[15]) && (r.res[15] != a[15]) : wide[DataW];
      end
      OP_SUB: begin
        r.res = a - b;
        r.ovf = sgn ? (a[15] != b[15]) && (r.res[15] != a[15]) : (a < b);
      end
      OP_MUL: begin
        p = ProdW'(a) * ProdW'(b);
        r.res  = p[DataW-1:0];
        r.prod = p;
        r.ovf  = (p[ProdW-1:DataW] != '0);
      end
      default: begin
        if (b == '0) r.dz = 1'b1;
        else begin
          r.res = a / b;
          r.rem = a % b;
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Check each returned transaction against the oldest expectation
  always @(posedge clk_i) begin
    alu_res_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) report_mismatch("unexpected result", result_o, 0);
      else begin
        w = expected_q.pop_front();
        if (result_o !== w.res) report_mismatch("result", result_o, w.res);
        if (wide_product_o !== w.prod)
          report_mismatch("wide_product", wide_product_o, w.prod);
        if (remainder_o !== w.rem) report_mismatch("remainder", remainder_o, w.rem);
        if (overflow_o !== w.ovf) report_mismatch("overflow", overflow_o, w.ovf);
        if (divide_by_zero_o !== w.dz)
          report_mismatch("divide_by_zero", divide_by_zero_o, w.dz);
      end
    end
  end

  // Receiver: random stall bursts, plus an optional long hold-off
  initial begin
    int unsigned burst;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles != 0) begin
        out_ready_i <= 1'b0;
        hold_cycles--;
      end else if (burst != 0) begin
        out_ready_i <= 1'b0;
        burst--;
      end else begin
        out_ready_i <= 1'b1;
        if (recv_gaps && $urandom_range(0, 5) == 0) burst = $urandom_range(1, 13);
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WdogLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_op(op_e op, logic [DataW-1:0] a, logic [DataW-1:0] b);
    int unsigned gap;
    if (send_gaps && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    operand_a_i <= a;
    operand_b_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    expected_q.push_back(alu_predict(op, a, b, mode_signed));
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 2) @(posedge clk_i);
  endtask

  // Write signed_mode while the pipeline is empty
  task automatic write_mode(logic sgn);
    cfg_valid_i       <= 1'b1;
    cfg_signed_mode_i <= sgn;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    mode_signed = sgn;
  endtask

  function automatic logic [DataW-1:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'h8000 ^ DataW'($urandom_range(0, 3));
      3: return DataW'($urandom_range(0, 15));
      default: return DataW'($urandom());
    endcase
  endfunction

  task automatic test_directed();
    logic [DataW-1:0] ext[6] = '{16'h0000, 16'h0001, 16'h7fff, 16'h8000,
                                 16'hffff, 16'h5a5a};
    for (int m = 0; m < 2; m++) begin
      write_mode(m[0]);
      for (int i = 0; i < 6; i++) begin
        send_op(OP_ADD, ext[i], ext[5 - i]);
        send_op(OP_SUB, ext[i], ext[(i + 3) % 6]);
      end
      send_op(OP_SUB, 16'h1234, 16'h0000);
      send_op(OP_SUB, 16'h0005, 16'h8000);
      send_op(OP_SUB, 16'h8000, 16'h8000);
      send_op(OP_MUL, 16'hffff, 16'hffff);
      send_op(OP_MUL, 16'h00ff, 16'h0101);
      send_op(OP_MUL, 16'h0100, 16'h0100);
      send_op(OP_DIV, 16'hffff, 16'h0000);
      send_op(OP_DIV, 16'hffff, 16'h0001);
      send_op(OP_DIV, 16'h0007, 16'hffff);
      send_op(OP_DIV, 16'h1234, 16'h0010);
      drain_results();
    end
  endtask

  task automatic test_random(int unsigned count);
    for (int unsigned i = 0; i < count; i++)
      send_op(op_e'($urandom_range(0, 3)), rand_operand(), rand_operand());
  endtask

  // Receiver holds off long enough that the row fills and stalls the input
  task automatic test_backpressure();
    hold_cycles = 60;
    test_random(50);
    drain_results();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_signed_mode_i = 1'b0;
    in_valid_i = 1'b0;
    operation_i = OP_ADD;
    operand_a_i = '0;
    operand_b_i = '0;
    mode_signed = 1'b0;
    error_count = 0;
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    hold_cycles = 0;
    idle_cycles = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    write_mode(1'b0);
    test_random(600);
    drain_results();
    write_mode(1'b1);
    test_random(600);
    test_backpressure();
    write_mode(1'b0);
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    test_random(300);
    drain_results();
    write_mode(1'b1);
    test_random(300);
    drain_results();

    if (error_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
`default_nettype wire

// File: files.f
design/alu16_pkg.sv
design/alu16_cell.sv
design/alu16_add_sub_mul_div.sv
design/alu16_checker.sv
tb/sv/testbench.sv
